FILE: hdl/pcd_pkg.sv
// Shared types, codes and constants of the pointer click/drag classifier.
package pcd_pkg;

	localparam int COORD_BITS = 12;
	localparam int CW         = COORD_BITS;
	localparam int CFG_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int TSQ_W      = 2 * CFG_W;
	localparam int SQ_W       = 2 * CW + 1;
	localparam int FLIP_W     = (CW > CFG_W) ? CW : CFG_W;
	localparam int CMP_W      = (SQ_W > TSQ_W) ? SQ_W : TSQ_W;

	localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_DRAG_THR   = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0] WIN_HEIGHT_RST = CFG_W'(768);
	localparam int               DRAG_THR_RST   = 5;
	localparam logic [TSQ_W-1:0] THR_SQ_RST     = TSQ_W'(DRAG_THR_RST * DRAG_THR_RST);

	// Unit step: a drag update whose squared step from the last point is at most this is dropped.
	localparam logic [CW-1:0] UNIT_DIST = CW'(1);

	localparam logic [1:0] BTN_LEFT  = 2'd0;
	localparam logic [1:0] BTN_RIGHT = 2'd1;

	typedef enum logic [1:0] {
		OP_POLL = 2'd0,
		OP_DOWN = 2'd1,
		OP_MOVE = 2'd2,
		OP_UP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		G_NONE      = 3'd0,
		G_LDOWN     = 3'd1,
		G_RDOWN     = 3'd2,
		G_LDRAGGING = 3'd3,
		G_LUP       = 3'd4,
		G_LDRAG     = 3'd5
	} gesture_t;

	typedef struct packed {
		op_t             op;
		logic [1:0]      btn;
		logic [CW-1:0]   x;
		logic [CW-1:0]   y;
	} item_t;

	typedef struct packed {
		gesture_t        gest;
		logic            pend;
		logic [CW-1:0]   bx;
		logic [CW-1:0]   by;
		logic [CW-1:0]   lx;
		logic [CW-1:0]   ly;
	} state_t;

	typedef struct packed {
		gesture_t        gesture;
		logic [CW-1:0]   start_x;
		logic [CW-1:0]   start_y;
		logic [CW-1:0]   end_x;
		logic [CW-1:0]   end_y;
	} rpt_t;

	localparam state_t ST_RST = '{
		gest: G_NONE, pend: 1'b0, bx: '0, by: '0, lx: '0, ly: '0
	};

endpackage

FILE: hdl/pcd_ifs.sv
// Valid/ready channel interfaces: pointer events, gesture reports, register writes.
interface pcd_evt_if import pcd_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [1:0]    opcode;
	logic [1:0]    button;
	logic [CW-1:0] pos_x;
	logic [CW-1:0] pos_y;

	modport source(output valid, output opcode, output button, output pos_x,
		output pos_y, input ready);
	modport sink(input valid, input opcode, input button, input pos_x,
		input pos_y, output ready);
endinterface

interface pcd_rpt_if import pcd_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [2:0]    gesture;
	logic [CW-1:0] start_x;
	logic [CW-1:0] start_y;
	logic [CW-1:0] end_x;
	logic [CW-1:0] end_y;

	modport source(output valid, output gesture, output start_x, output start_y,
		output end_x, output end_y, input ready);
	modport sink(input valid, input gesture, input start_x, input start_y,
		input end_x, input end_y, output ready);
endinterface

interface pcd_cfg_if import pcd_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

FILE: hdl/pcd_core.sv
// Gesture next-state and poll report logic for one event.
module pcd_core import pcd_pkg::*; (
	input  item_t            item,
	input  state_t           st,
	input  logic [TSQ_W-1:0] thr_sq,
	output state_t           st_nxt,
	output logic             res_v,
	output rpt_t             res
);

	function automatic state_t rec(gesture_t g, logic [CW-1:0] sx, logic [CW-1:0] sy,
		logic [CW-1:0] ex, logic [CW-1:0] ey);
		state_t s;
		s.gest = g;
		s.pend = 1'b1;
		s.bx   = sx;
		s.by   = sy;
		s.lx   = ex;
		s.ly   = ey;
		return s;
	endfunction

	function automatic logic [CW-1:0] absdiff(logic [CW-1:0] a, logic [CW-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	logic [CW-1:0]   dxb, dyb, dxl, dyl;
	logic [2*CW-1:0] sqx, sqy;
	logic [SQ_W-1:0] dist_sq;
	logic            held, far, moved;

	assign dxb = absdiff(item.x, st.bx);
	assign dyb = absdiff(item.y, st.by);
	assign dxl = absdiff(item.x, st.lx);
	assign dyl = absdiff(item.y, st.ly);

	assign sqx     = (2*CW)'(dxb) * (2*CW)'(dxb);
	assign sqy     = (2*CW)'(dyb) * (2*CW)'(dyb);
	assign dist_sq = SQ_W'(sqx) + SQ_W'(sqy);

	assign held = (st.gest == G_LDOWN) || (st.gest == G_LDRAGGING);
	assign far  = CMP_W'(dist_sq) > CMP_W'(thr_sq);
	// squared distance above one: a step over one on either axis, or a diagonal unit step
	assign moved = (dxl > UNIT_DIST) || (dyl > UNIT_DIST) ||
		((dxl == UNIT_DIST) && (dyl == UNIT_DIST));

	always_comb begin
		st_nxt      = st;
		res_v       = 1'b0;
		res.gesture = st.pend ? st.gest : G_NONE;
		res.start_x = st.bx;
		res.start_y = st.by;
		res.end_x   = st.lx;
		res.end_y   = st.ly;
		unique case (item.op)
			OP_POLL: begin
				res_v       = 1'b1;
				st_nxt.pend = 1'b0;
			end
			OP_DOWN: begin
				if (item.btn == BTN_LEFT) begin
					st_nxt = rec(G_LDOWN, item.x, item.y, item.x, item.y);
				end else if (item.btn == BTN_RIGHT) begin
					st_nxt = rec(G_RDOWN, item.x, item.y, item.x, item.y);
				end
			end
			OP_MOVE: begin
				if (held && far) begin
					if (moved) begin
						st_nxt = rec(G_LDRAGGING, st.bx, st.by, item.x, item.y);
					end
				end else begin
					st_nxt.lx = item.x;
					st_nxt.ly = item.y;
				end
			end
			OP_UP: begin
				if (item.btn == BTN_LEFT) begin
					if (st.gest == G_LDOWN) begin
						st_nxt = rec(G_LUP, st.bx, st.by, item.x, item.y);
					end else if (st.gest == G_LDRAGGING) begin
						st_nxt = rec(G_LDRAG, st.bx, st.by, item.x, item.y);
					end
				end
			end
		endcase
	end

endmodule

FILE: hdl/pointer_click_drag_classifier.sv
// Top level of the pointer click/drag classifier.
//
// Channels (valid/ready, a beat moves when both are high):
//   evt - pointer events: opcode (poll, down, move, up), button, pos_x, pos_y.
//   rpt - one report beat per poll: gesture, start point and end point.
//   cfg - register writes: index 0 window height, index 1 drag threshold.
//         Always ready; other indexes are dropped. Write only while idle.
// Each event passes one input register (y is flipped there against the
// window height) and then the gesture logic, which updates the gesture
// state and, for a poll, loads the report register. A poll's report is
// offered on rpt once it has passed the input register and the report
// register. One event is taken every cycle unless a poll waits behind a
// full report register; the gesture state register feeds back through
// combinational logic alone. The drag threshold is squared when written,
// so the distance test is two small squares, an add and a compare.
// When rpt stalls, non-poll events keep flowing; a poll waiting behind a
// full report register holds the input stage and evt.ready drops.
// Reset clears the gesture state, the pending flag, both points and the
// valid bits, and loads the register defaults (height 768, threshold 5).
module pointer_click_drag_classifier import pcd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	pcd_evt_if.sink    evt,
	pcd_rpt_if.source  rpt,
	pcd_cfg_if.sink    cfg
);

	logic             v_s1;
	item_t            item_s1;
	logic [CFG_W-1:0] wh_q;
	logic [TSQ_W-1:0] thr_sq_q;
	state_t           st_q;
	state_t           st_nxt;
	logic             rpt_v_q;
	rpt_t             rpt_q;
	rpt_t             res;
	logic             res_v;
	logic             adv_s1, fire_s1, evt_fire, cfg_fire;
	logic [FLIP_W-1:0] wh_ext, ry_ext;
	logic [CW-1:0]    y_flip;
	logic [TSQ_W-1:0] thr_sq_new;

	// flip y against the window height, hold at zero below the bottom edge
	assign wh_ext = FLIP_W'(wh_q);
	assign ry_ext = FLIP_W'(evt.pos_y);
	assign y_flip = (wh_ext > ry_ext) ? CW'(wh_ext - ry_ext) : '0;

	// a poll needs the report register free; anything else always advances
	assign adv_s1   = (item_s1.op != OP_POLL) || !rpt_v_q || rpt.ready;
	assign fire_s1  = v_s1 && adv_s1;
	assign evt.ready = !v_s1 || adv_s1;
	assign evt_fire = evt.valid && evt.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (evt.ready) begin
			v_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt_fire) begin
			item_s1.op  <= op_t'(evt.opcode);
			item_s1.btn <= evt.button;
			item_s1.x   <= evt.pos_x;
			item_s1.y   <= y_flip;
		end
	end

	pcd_core u_core (
		.item   (item_s1),
		.st     (st_q),
		.thr_sq (thr_sq_q),
		.st_nxt (st_nxt),
		.res_v  (res_v),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RST;
		end else if (fire_s1) begin
			st_q <= st_nxt;
		end
	end

	// report register: load on a poll, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_v_q <= 1'b0;
		end else if (fire_s1 && res_v) begin
			rpt_v_q <= 1'b1;
		end else if (rpt.ready) begin
			rpt_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && res_v) begin
			rpt_q <= res;
		end
	end

	assign rpt.valid   = rpt_v_q;
	assign rpt.gesture = rpt_q.gesture;
	assign rpt.start_x = rpt_q.start_x;
	assign rpt.start_y = rpt_q.start_y;
	assign rpt.end_x   = rpt_q.end_x;
	assign rpt.end_y   = rpt_q.end_y;

	// configuration: keep the threshold squared so the drag test needs no extra multiply
	assign cfg.ready  = 1'b1;
	assign cfg_fire   = cfg.valid && cfg.ready;
	assign thr_sq_new = TSQ_W'(cfg.data) * TSQ_W'(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wh_q     <= WIN_HEIGHT_RST;
			thr_sq_q <= THR_SQ_RST;
		end else if (cfg_fire) begin
			unique case (cfg.index)
				REG_WIN_HEIGHT: wh_q     <= cfg.data;
				REG_DRAG_THR:   thr_sq_q <= thr_sq_new;
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hdl/pcd_checker.sv
// Port-level checks of the pointer click/drag classifier and their bind.
module pcd_checker import pcd_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                evt_valid,
	input logic                evt_ready,
	input logic                rpt_valid,
	input logic                rpt_ready,
	input logic [3+4*CW-1:0]   rpt_payload
);

	// a stalled report beat stays offered
	a_rpt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> rpt_valid)
		else $error("report beat dropped while stalled");

	// a stalled report beat keeps its payload
	a_rpt_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=> $stable(rpt_payload))
		else $error("report payload changed while stalled");

	// a fresh report comes from an event that passed the input register and then the gesture logic
	a_rpt_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(evt_valid && evt_ready, 2))
		else $error("report appeared without a poll two cycles earlier");

	// events are held back only by a stalled report
	a_evt_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!evt_ready |-> rpt_valid && !rpt_ready)
		else $error("event channel stalled without a stalled report");

endmodule

bind pointer_click_drag_classifier pcd_checker u_pcd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.evt_valid   (evt.valid),
	.evt_ready   (evt.ready),
	.rpt_valid   (rpt.valid),
	.rpt_ready   (rpt.ready),
	.rpt_payload ({rpt.gesture, rpt.start_x, rpt.start_y, rpt.end_x, rpt.end_y})
);
